[sv/wqt_pkg.sv]
// Shared types and constants for the waypoint queue tracker.
package wqt_pkg;

	localparam int HOVER_W      = 16;
	localparam int MARGIN_RESET = 128;
	localparam int LEVEL_RESET  = 512;
	localparam int HOVER_RESET  = 500;

	typedef enum logic [1:0] {
		PH_HOVER = 2'd0,
		PH_WAIT  = 2'd1,
		PH_TRACK = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_MARGIN = 2'd0,
		REG_LEVEL  = 2'd1,
		REG_HOVER  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HEAD,
		ST_NEXT,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic   capture;
		logic   push;
		logic   hover_inc;
		logic   hover_set;
		logic   set_done;
		logic   set_tracked;
		logic   rd_en;
		logic   rd_next;
		logic   sp_load;
		logic   pop;
		logic   res_ld;
		phase_t phase;
	} ctl_cmd_t;

	typedef struct packed {
		logic   is_add;
		logic   mission_done;
		logic   hovering;
		logic   empty;
		logic   has_tracked;
		logic   reached;
		logic   more;
		phase_t cur_phase;
	} dp_stat_t;

endpackage

[sv/wqt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module wqt_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/wqt_ctrl.sv]
// Sequencing state machine for the waypoint queue tracker.
module wqt_ctrl
	import wqt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.is_add || stat.mission_done || stat.hovering || stat.empty) begin
					state_nxt = ST_REPLY;
				end else begin
					state_nxt = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (stat.reached && stat.more) begin
					state_nxt = ST_NEXT;
				end else begin
					state_nxt = ST_REPLY;
				end
			end
			ST_NEXT:  state_nxt = ST_REPLY;
			ST_REPLY: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd   = '0;
		busy  = 1'b1;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_EXEC: begin
				if (stat.is_add) begin
					cmd.push   = 1'b1;
					cmd.res_ld = 1'b1;
					cmd.phase  = stat.cur_phase;
				end else if (stat.mission_done) begin
					cmd.res_ld = 1'b1;
					cmd.phase  = PH_DONE;
				end else if (stat.hovering) begin
					cmd.hover_inc = 1'b1;
					cmd.hover_set = 1'b1;
					cmd.res_ld    = 1'b1;
					cmd.phase     = PH_HOVER;
				end else if (stat.empty) begin
					cmd.res_ld = 1'b1;
					if (stat.has_tracked) begin
						cmd.set_done = 1'b1;
						cmd.phase    = PH_DONE;
					end else begin
						cmd.hover_set = 1'b1;
						cmd.phase     = PH_WAIT;
					end
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			ST_HEAD: begin
				cmd.sp_load     = 1'b1;
				cmd.set_tracked = 1'b1;
				cmd.res_ld      = 1'b1;
				cmd.phase       = PH_TRACK;
				if (stat.reached) begin
					cmd.pop = 1'b1;
					if (stat.more) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_NEXT: begin
				cmd.sp_load = 1'b1;
			end
			ST_REPLY: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_head_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEAD) |-> ($past(state_q) == ST_EXEC))
		else $error("head compare entered without a queue read");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EXEC))
		else $error("accepted command did not start execution");

endmodule

[sv/wqt_dp.sv]
// Queue, pointers, counters, setpoint and configuration registers of the tracker.
module wqt_dp
	import wqt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctl_cmd_t                      cmd,
	output dp_stat_t                      stat,
	input  logic                          in_cmd,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [COORD_WIDTH-1:0] in_z,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [((COORD_WIDTH > HOVER_W) ? COORD_WIDTH : HOVER_W)-1:0] cfg_data,
	output logic signed [COORD_WIDTH-1:0] sp_x,
	output logic signed [COORD_WIDTH-1:0] sp_y,
	output logic signed [COORD_WIDTH-1:0] sp_z,
	output phase_t                        phase_o,
	output logic                          dropped_o
);

	localparam int CW    = COORD_WIDTH;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = 3 * CW;

	logic [CW-2:0]           margin_q;
	logic signed [CW-1:0]    level_q;
	logic [HOVER_W-1:0]      hover_ticks_q;
	logic [HOVER_W-1:0]      hover_cnt_q;
	logic [PTR_W-1:0]        rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    tracked_q, mdone_q;
	logic                    cmd_q;
	logic signed [CW-1:0]    px_q, py_q, pz_q;
	logic signed [CW-1:0]    spx_q, spy_q, spz_q;
	phase_t                  phase_q;
	logic                    dropped_q;

	logic                    full;
	logic signed [CW-1:0]    neg_x;
	logic [ENT_W-1:0]        rdata;
	logic signed [CW-1:0]    hx, hy, hz;
	logic [PTR_W-1:0]        rd_ptr_inc, wr_ptr_inc, raddr;
	logic                    near_x, near_y, near_z;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic near_axis(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b, input logic [CW-2:0] m);
		logic signed [CW:0] diff;
		logic [CW:0]        mag;
		diff = {a[CW-1], a} - {b[CW-1], b};
		mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
		return mag < {2'b00, m};
	endfunction

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign neg_x      = (px_q == {1'b1, {(CW-1){1'b0}}}) ? {1'b0, {(CW-1){1'b1}}} : -px_q;
	assign rd_ptr_inc = wrap_inc(rd_ptr_q);
	assign wr_ptr_inc = wrap_inc(wr_ptr_q);
	assign raddr      = cmd.rd_next ? rd_ptr_inc : rd_ptr_q;
	assign {hz, hy, hx} = rdata;

	wqt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push && !full),
		.waddr(wr_ptr_q),
		.wdata({pz_q, py_q, neg_x}),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign near_x = near_axis(px_q, hx, margin_q);
	assign near_y = near_axis(py_q, hy, margin_q);
	assign near_z = near_axis(pz_q, hz, margin_q);

	always_comb begin
		stat.is_add       = !cmd_q;
		stat.mission_done = mdone_q;
		stat.hovering     = hover_cnt_q < hover_ticks_q;
		stat.empty        = (count_q == '0);
		stat.has_tracked  = tracked_q;
		stat.reached      = near_x && near_y && near_z;
		stat.more         = (count_q > CNT_W'(1));
		if (mdone_q) begin
			stat.cur_phase = PH_DONE;
		end else if (hover_cnt_q < hover_ticks_q) begin
			stat.cur_phase = PH_HOVER;
		end else if (tracked_q) begin
			stat.cur_phase = PH_TRACK;
		end else begin
			stat.cur_phase = PH_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q      <= (CW-1)'(MARGIN_RESET);
			level_q       <= CW'(LEVEL_RESET);
			hover_ticks_q <= HOVER_W'(HOVER_RESET);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MARGIN: margin_q      <= cfg_data[CW-2:0];
				REG_LEVEL:  level_q       <= cfg_data[CW-1:0];
				REG_HOVER:  hover_ticks_q <= cfg_data[HOVER_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			hover_cnt_q <= '0;
			tracked_q   <= 1'b0;
			mdone_q     <= 1'b0;
			spx_q       <= '0;
			spy_q       <= '0;
			spz_q       <= CW'(LEVEL_RESET);
			phase_q     <= PH_HOVER;
			dropped_q   <= 1'b0;
		end else begin
			if (cmd.push && !full) begin
				wr_ptr_q <= wr_ptr_inc;
				count_q  <= count_q + 1'b1;
			end
			if (cmd.pop) begin
				rd_ptr_q <= rd_ptr_inc;
				count_q  <= count_q - 1'b1;
			end
			if (cmd.hover_inc) begin
				hover_cnt_q <= hover_cnt_q + 1'b1;
			end
			if (cmd.set_tracked) begin
				tracked_q <= 1'b1;
			end
			if (cmd.set_done) begin
				mdone_q <= 1'b1;
			end
			if (cmd.hover_set) begin
				spx_q <= '0;
				spy_q <= '0;
				spz_q <= level_q;
			end else if (cmd.sp_load) begin
				spx_q <= hx;
				spy_q <= hy;
				spz_q <= hz;
			end
			if (cmd.res_ld) begin
				phase_q   <= cmd.phase;
				dropped_q <= cmd.push && full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			px_q  <= in_x;
			py_q  <= in_y;
			pz_q  <= in_z;
		end
	end

	assign sp_x      = spx_q;
	assign sp_y      = spy_q;
	assign sp_z      = spz_q;
	assign phase_o   = phase_q;
	assign dropped_o = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop from an empty queue");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && full) |=> ($stable(count_q) && $stable(wr_ptr_q) && dropped_q))
		else $error("full queue changed on a dropped add");

endmodule

[sv/waypoint_queue_tracker_top.sv]
// Top level of the waypoint queue tracker: controller, datapath and port wiring.
//
// The block keeps a FIFO of 3-D waypoints and turns position ticks into
// setpoints. A command is taken at a rising edge where start is high and busy
// is low; busy then stays high until its result has been shown. Each command
// gives exactly one result, presented on set_x, set_y, set_z, phase and
// dropped for one clock cycle while done is high; the receiver cannot stall,
// so it must take the transfer in that cycle. An add command (cmd = 0) shows
// its result right after the execute state, as does a tick that hovers,
// waits or finishes. A tick that tracks the queue head reads the head and
// compares it first, and when the head is reached and another waypoint
// follows it also reads the next entry before the result, because the
// waypoint store is a single-read-port RAM with a registered read: one read
// fetches the head and a second fetches the next entry. An idle state with
// busy low follows each result, and the next command can be taken at the
// edge that ends it. Configuration registers (0: arrival margin, 1: hover
// level, 2: hover tick count) are written through cfg_we, cfg_index and
// cfg_data at any edge and should only be changed while busy is low; an index
// beyond the list is ignored. There is no clearing pass after reset: the queue
// is empty and accepts commands at once.
module waypoint_queue_tracker_top
	import wqt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64,
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [((COORD_WIDTH > HOVER_W) ? COORD_WIDTH : HOVER_W)-1:0] cfg_data,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] set_x,
	output logic signed [COORD_WIDTH-1:0] set_y,
	output logic signed [COORD_WIDTH-1:0] set_z,
	output logic [1:0]                    phase,
	output logic                          dropped
);

	// Commands from the controller into the datapath, status back.
	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;
	phase_t   phase_w;

	wqt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (dp_stat),
		.busy  (busy),
		.done  (done),
		.cmd   (ctl_cmd)
	);

	wqt_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.in_cmd   (cmd),
		.in_x     (pos_x),
		.in_y     (pos_y),
		.in_z     (pos_z),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sp_x     (set_x),
		.sp_y     (set_y),
		.sp_z     (set_z),
		.phase_o  (phase_w),
		.dropped_o(dropped)
	);

	// The phase code travels as the package enum and leaves as plain bits.
	assign phase = phase_w;

endmodule

[bench/waypoint_queue_tracker_top_test.sv]
// Self-checking testbench for the waypoint queue tracker top level.
`timescale 1ns / 100ps

module waypoint_queue_tracker_top_test
	import wqt_pkg::*;
();

	// Block geometry, matched to the instance parameters below.
	localparam int     CW     = 24;
	localparam int     QDEPTH = 64;
	localparam int     CFG_W  = (CW > HOVER_W) ? CW : HOVER_W;
	localparam longint CMAX   = (longint'(1) << (CW - 1)) - 1;
	localparam longint CMIN   = -(longint'(1) << (CW - 1));

	// Command codes carried on the cmd port.
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Cycles allowed after the last result for stray strobes to show up.
	// The slowest command runs through the execute, head, next, reply and idle states.
	localparam int SETTLE = 10;
	// Watchdog limit: roughly ten times the slowest legal run of this stimulus.
	localparam int LIMIT  = 400000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		point_t sp;
		phase_t ph;
		logic   drop;
	} setpoint_t;

	// The scoreboard keeps its own copy of the waypoint queue, the hover and
	// mission status and the three registers. Every accepted command is run
	// through it at once, and the setpoint it predicts waits in a queue
	// until the block strobes the matching result.
	class mission_predictor;
		point_t        route[$];
		setpoint_t     due_setpoints[$];
		int unsigned   hovered;
		bit            tracked;
		bit            finished;
		point_t        last_sp;
		logic [CW-2:0] margin;
		coord_t        level;
		logic [HOVER_W-1:0] hover_limit;
		int            faults;

		function new();
			margin      = (CW-1)'(MARGIN_RESET);
			level       = coord_t'(LEVEL_RESET);
			hover_limit = HOVER_W'(HOVER_RESET);
			last_sp     = '{x: '0, y: '0, z: coord_t'(LEVEL_RESET)};
			hovered     = 0;
			tracked     = 1'b0;
			finished    = 1'b0;
			faults      = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_MARGIN: margin = data[CW-2:0];
				REG_LEVEL: level = data[CW-1:0];
				REG_HOVER: hover_limit = data[HOVER_W-1:0];
				default: ;
			endcase
		endfunction

		function phase_t status();
			if (finished)
				return PH_DONE;
			if (hovered < hover_limit)
				return PH_HOVER;
			return tracked ? PH_TRACK : PH_WAIT;
		endfunction

		function bit near(coord_t p, coord_t h);
			longint delta;
			delta = longint'(p) - longint'(h);
			if (delta < 0)
				delta = -delta;
			return delta < longint'(margin);
		endfunction

		function void note_item(logic c, coord_t px, coord_t py, coord_t pz);
			setpoint_t want;
			point_t    hover_sp;
			point_t    head;
			point_t    wp;
			longint    nx;
			hover_sp  = '{x: '0, y: '0, z: level};
			want.drop = 1'b0;
			if (c == CMD_ADD) begin
				if (route.size() >= QDEPTH) begin
					want.drop = 1'b1;
				end else begin
					// x is stored negated; the most negative value saturates.
					nx = -longint'(px);
					if (nx > CMAX)
						nx = CMAX;
					wp.x = coord_t'(nx);
					wp.y = py;
					wp.z = pz;
					route = {route, wp};
				end
				want.ph = status();
			end else if (finished) begin
				want.ph = PH_DONE;
			end else if (hovered < hover_limit) begin
				hovered++;
				last_sp = hover_sp;
				want.ph = PH_HOVER;
			end else if (route.size() == 0) begin
				if (tracked) begin
					finished = 1'b1;
					want.ph  = PH_DONE;
				end else begin
					last_sp = hover_sp;
					want.ph = PH_WAIT;
				end
			end else begin
				head    = route[0];
				last_sp = head;
				if (near(px, head.x) && near(py, head.y) && near(pz, head.z)) begin
					void'(route.pop_front());
					if (route.size() != 0)
						last_sp = route[0];
				end
				tracked = 1'b1;
				want.ph = PH_TRACK;
			end
			want.sp = last_sp;
			due_setpoints = {due_setpoints, want};
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			faults++;
		endtask

		task check_result(coord_t sx, coord_t sy, coord_t sz, logic [1:0] ph,
				logic drop);
			setpoint_t want;
			if (due_setpoints.size() == 0) begin
				report($sformatf("result (%0d,%0d,%0d) phase %0d with none expected",
					sx, sy, sz, ph));
				return;
			end
			want = due_setpoints.pop_front();
			if (sx !== want.sp.x)
				report($sformatf("set_x %0d, expected %0d", sx, want.sp.x));
			if (sy !== want.sp.y)
				report($sformatf("set_y %0d, expected %0d", sy, want.sp.y));
			if (sz !== want.sp.z)
				report($sformatf("set_z %0d, expected %0d", sz, want.sp.z));
			if (ph !== want.ph)
				report($sformatf("phase %0d, expected %0d", ph, want.ph));
			if (drop !== want.drop)
				report($sformatf("dropped %0b, expected %0b", drop, want.drop));
		endtask
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             cmd       = CMD_ADD;
	coord_t           pos_x     = '0;
	coord_t           pos_y     = '0;
	coord_t           pos_z     = '0;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = REG_MARGIN;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	coord_t           set_x;
	coord_t           set_y;
	coord_t           set_z;
	logic [1:0]       phase;
	logic             dropped;

	mission_predictor board;
	int               cycles = 0;
	// When set, the sender offers every command with no gap at all.
	bit               steady = 1'b0;

	waypoint_queue_tracker_top #(
		.QUEUE_DEPTH(QDEPTH),
		.COORD_WIDTH(CW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.set_x(set_x),
		.set_y(set_y),
		.set_z(set_z),
		.phase(phase),
		.dropped(dropped)
	);

	always #1 clk = ~clk;

	// Results cannot be held off, so every strobed cycle is one transfer and
	// is checked on the edge that closes it. Outputs are sampled before the
	// block's own updates at that edge take effect.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(set_x, set_y, set_z, phase, dropped);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("waypoint_queue_tracker_top_test: errors");
			$finish;
		end
	end

	// Offers one command after a random idle gap and returns on the edge at
	// which the block takes the transfer. Start is left high on return so a
	// following command with no gap keeps it high without a glitch; the
	// prediction is made at the accepting edge.
	task automatic send(logic c, coord_t x, coord_t y, coord_t z);
		int unsigned gap;
		gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (busy);
		board.note_item(c, x, y, z);
	endtask

	// Lowers start and waits until every predicted result has been seen,
	// then lets the block settle. Register writes happen only after this.
	task automatic quiesce();
		start <= 1'b0;
		while (board.due_setpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Mostly full-range coordinates, with the two extremes now and then.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'(CMIN);
			1: return coord_t'(CMAX);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// One position axis relative to the queue head. A hit lands strictly
	// inside the margin; a miss lands on the margin or just beyond it, which
	// is where the strict compare matters.
	function automatic coord_t aim_axis(coord_t h, bit hit);
		longint m;
		longint off;
		m = longint'(board.margin);
		if (hit)
			off = (m <= 1) ? 0 : longint'($urandom_range(0, int'(2 * m - 2))) - (m - 1);
		else begin
			case ($urandom_range(0, 3))
				0: off = m;
				1: off = -m;
				2: off = m + $urandom_range(0, 255);
				default: off = -(m + $urandom_range(0, 255));
			endcase
		end
		return coord_t'(longint'(h) + off);
	endfunction

	// A tick that would end the mission is turned into an add, so the done
	// phase is entered only by the closing sequence of the run.
	task automatic probe(coord_t x, coord_t y, coord_t z);
		if (board.route.size() == 0 && board.tracked)
			send(CMD_ADD, x, y, z);
		else
			send(CMD_TICK, x, y, z);
	endtask

	// A position tick steered toward the current head of the queue.
	task automatic chase(bit hit);
		point_t h;
		if (board.route.size() == 0) begin
			probe(rand_coord(), rand_coord(), rand_coord());
		end else begin
			h = board.route[0];
			send(CMD_TICK, aim_axis(h.x, hit || $urandom_range(0, 1)),
				aim_axis(h.y, hit || $urandom_range(0, 1)),
				aim_axis(h.z, hit || $urandom_range(0, 1)));
		end
	endtask

	// Random traffic: bursts of waypoints followed by runs of ticks that
	// home in on them, with some plain noise and an occasional flood that
	// overruns the queue.
	task automatic run_phase(int budget);
		int issued;
		int pick;
		int n;
		issued = 0;
		while (issued < budget) begin
			pick = $urandom_range(0, 99);
			if (pick == 0) begin
				n = QDEPTH - board.route.size() + $urandom_range(1, 3);
				repeat (n) send(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
			end else if (pick <= 18) begin
				n = $urandom_range(1, 5);
				repeat (n) send(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
			end else if (pick <= 26) begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(0, 1))
						send(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
					else
						probe(rand_coord(), rand_coord(), rand_coord());
				end
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) chase($urandom_range(0, 99) < 55);
			end
			issued += n;
			// Now and then the sender holds off until the block has drained.
			if ($urandom_range(0, 63) == 0)
				quiesce();
		end
	endtask

	initial begin
		point_t           h;
		logic [CFG_W-1:0] data;
		int unsigned      hv;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the first tick hovers at the reset level.
		send(CMD_TICK, 24'sd100, -24'sd100, 24'sd7);

		// Hover is over and nothing is queued yet, so the block waits at the
		// lowest possible level.
		quiesce();
		write_reg(REG_HOVER, CFG_W'(1));
		write_reg(REG_LEVEL, CFG_W'(CMIN));
		send(CMD_TICK, rand_coord(), rand_coord(), rand_coord());
		// Extreme waypoints; the first one has the most negative x.
		send(CMD_ADD, coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN));
		send(CMD_ADD, coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX));
		send(CMD_ADD, '0, '0, '0);

		// A zero margin never counts as arrival, even at the exact head.
		// The write to the unused index must change nothing.
		quiesce();
		write_reg(REG_MARGIN, '0);
		write_reg(REG_NONE, '1);
		h = board.route[0];
		send(CMD_TICK, h.x, h.y, h.z);

		// A margin of one: an exact hit arrives, one step off does not.
		quiesce();
		write_reg(REG_MARGIN, CFG_W'(1));
		h = board.route[0];
		send(CMD_TICK, h.x, h.y, h.z);
		h = board.route[0];
		send(CMD_TICK, coord_t'(longint'(h.x) + 1), h.y, h.z);

		// The widest margin: opposite corners miss, just inside arrives.
		quiesce();
		write_reg(REG_MARGIN, CFG_W'(CMAX));
		send(CMD_TICK, coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN));
		h = board.route[0];
		send(CMD_TICK, coord_t'(longint'(h.x) + CMAX - 1),
			coord_t'(longint'(h.y) + CMAX - 1), coord_t'(longint'(h.z) - CMAX + 1));

		// Raising the hover count past the ticks already seen brings the
		// hover back, in the middle of tracking.
		quiesce();
		write_reg(REG_HOVER, CFG_W'(3));
		send(CMD_TICK, rand_coord(), rand_coord(), rand_coord());
		send(CMD_ADD, 24'sd5, 24'sd6, 24'sd7);
		send(CMD_TICK, rand_coord(), rand_coord(), rand_coord());

		// No hover at all, top level, and tracking resumes.
		quiesce();
		write_reg(REG_HOVER, '0);
		write_reg(REG_LEVEL, CFG_W'(CMAX));
		h = board.route[0];
		send(CMD_TICK, h.x, h.y, h.z);

		// Random phases, each with its own register settings and idling.
		for (int p = 0; p < 8; p++) begin
			steady = (p == 1 || p == 6);
			quiesce();
			case (p)
				0: data = '0;
				1: data = CFG_W'(CMAX);
				default: begin
					case ($urandom_range(0, 3))
						0: data = CFG_W'(1);
						1: data = CFG_W'(128);
						2: data = CFG_W'($urandom_range(2, 4096));
						default: data = CFG_W'($urandom);
					endcase
				end
			endcase
			write_reg(REG_MARGIN, data);
			case (p)
				2: data = CFG_W'(CMIN);
				3: data = CFG_W'(CMAX);
				default: data = CFG_W'($urandom);
			endcase
			write_reg(REG_LEVEL, data);
			case (p)
				4: hv = 16'hFFFF;
				5: hv = 0;
				default: begin
					hv = board.hovered + $urandom_range(0, 20);
					if (hv > 16'hFFFF)
						hv = 16'hFFFF;
				end
			endcase
			// Bits above the hover count field carry noise and are ignored.
			data = CFG_W'($urandom);
			data[HOVER_W-1:0] = hv[HOVER_W-1:0];
			write_reg(REG_HOVER, data);
			run_phase((p == 4) ? 60 : 270);
		end

		// Closing sequence: drain the queue, end the mission, and show that
		// the done phase holds for ticks and for adds.
		steady = 1'b0;
		quiesce();
		write_reg(REG_HOVER, '0);
		write_reg(REG_MARGIN, CFG_W'(CMAX));
		while (board.route.size() != 0) begin
			h = board.route[0];
			send(CMD_TICK, h.x, h.y, h.z);
		end
		send(CMD_TICK, rand_coord(), rand_coord(), rand_coord());
		send(CMD_TICK, rand_coord(), rand_coord(), rand_coord());
		send(CMD_ADD, rand_coord(), rand_coord(), rand_coord());
		h = board.route[0];
		send(CMD_TICK, h.x, h.y, h.z);

		// Every prediction must be matched before the final verdict.
		quiesce();
		if (board.faults == 0)
			$display("waypoint_queue_tracker_top_test: clean");
		else
			$display("waypoint_queue_tracker_top_test: errors");
		$finish;
	end

endmodule
